// File: sv/esp_pkg.sv
// Shared types and constants for the entry stream parser/validator.
package esp_pkg;

  localparam int DEST_W = 12;

  // byte_kind codes
  localparam logic [2:0] KIND_TAG     = 3'd0;
  localparam logic [2:0] KIND_NLEN    = 3'd1;
  localparam logic [2:0] KIND_NAME    = 3'd2;
  localparam logic [2:0] KIND_CSIZE   = 3'd3;
  localparam logic [2:0] KIND_CONTENT = 3'd4;
  localparam logic [2:0] KIND_IGNORED = 3'd5;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BAD_TAG  = 3'd1;
  localparam status_t ST_VARINT   = 3'd2;
  localparam status_t ST_NAME_LEN = 3'd3;
  localparam status_t ST_SLASH    = 3'd4;
  localparam status_t ST_NUL      = 3'd5;
  localparam status_t ST_DOT      = 3'd6;
  localparam status_t ST_TRUNC    = 3'd7;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] LEB_DATA_MASK = 8'h7f;
  localparam logic [7:0] LEB_CONT_MASK = 8'h80;
  localparam logic [3:0] LEB_MAX_BYTES = 4'd10;

  typedef enum logic [4:0] {
    PH_TAG     = 5'b00001,
    PH_NLEN    = 5'b00010,
    PH_NAME    = 5'b00100,
    PH_CSIZE   = 5'b01000,
    PH_CONTENT = 5'b10000
  } phase_t;

  // per-name component tracking
  typedef struct packed {
    logic       at_start;
    logic [1:0] comp_len;
    logic       all_dots;
    status_t    pending;
  } name_st_t;

  localparam name_st_t NAME_INIT = '{at_start: 1'b1, comp_len: 2'd0,
                                     all_dots: 1'b1, pending: ST_OK};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] byte_kind;
    logic       entry_is_dir;
    logic       entry_done;
    status_t    status;
    logic       stream_ok;
  } out_beat_t;

endpackage

// File: sv/esp_varint.sv
// LEB128 accumulate step: folds one byte into the running value.
module esp_varint (
  input  logic [63:0] value,
  input  logic [3:0]  count,
  input  logic [7:0]  data_byte,
  output logic [63:0] value_next,
  output logic [3:0]  count_next,
  output logic        complete,
  output logic        too_long
);

  logic [6:0]  shamt;
  logic [63:0] contrib;
  logic [7:0]  payload;

  always_comb begin
    payload    = data_byte & esp_pkg::LEB_DATA_MASK;
    shamt      = 7'(count) * 7'd7;
    contrib    = {56'd0, payload} << shamt;  // bits past 63 fall off
    value_next = value | contrib;
    count_next = count + 4'd1;
    complete   = (data_byte & esp_pkg::LEB_CONT_MASK) == 8'd0;
    too_long   = !complete && (count_next >= esp_pkg::LEB_MAX_BYTES);
  end

endmodule

// File: sv/esp_name_step.sv
// Name byte checker: slash, NUL and dot-component tracking for one byte.
module esp_name_step (
  input  esp_pkg::name_st_t cur,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output esp_pkg::name_st_t nxt
);

  esp_pkg::name_st_t st;

  always_comb begin
    st = cur;
    if (cur.at_start && data_byte == esp_pkg::CH_SLASH) begin
      st.pending = esp_pkg::ST_SLASH;
    end
    st.at_start = 1'b0;
    if (data_byte == esp_pkg::CH_NUL &&
        (st.pending == esp_pkg::ST_OK || st.pending == esp_pkg::ST_DOT)) begin
      st.pending = esp_pkg::ST_NUL;
    end
    if (data_byte == esp_pkg::CH_SLASH) begin
      if (st.all_dots && (st.comp_len == 2'd1 || st.comp_len == 2'd2) &&
          st.pending == esp_pkg::ST_OK) begin
        st.pending = esp_pkg::ST_DOT;
      end
      st.comp_len = 2'd0;
      st.all_dots = 1'b1;
    end else begin
      if (st.comp_len != 2'd3) begin
        st.comp_len = st.comp_len + 2'd1;
      end
      if (data_byte != esp_pkg::CH_DOT) begin
        st.all_dots = 1'b0;
      end
    end
    // end of name closes the open component
    if (final_byte) begin
      if (st.all_dots && (st.comp_len == 2'd1 || st.comp_len == 2'd2) &&
          st.pending == esp_pkg::ST_OK) begin
        st.pending = esp_pkg::ST_DOT;
      end
      st.comp_len = 2'd0;
      st.all_dots = 1'b1;
    end
    nxt = st;
  end

endmodule

// File: sv/entry_stream_parser_validator.sv
// Top level of the archive entry stream parser/validator.
//
// Input channel: one stream byte per beat (data_byte, last_byte) on
//   in_valid / in_stall. Output channel: one result beat per input beat
//   (byte_kind, entry_is_dir, entry_done, status, stream_ok) on
//   out_valid / out_stall.
// Config: cfg_we writes cfg_data into dest_length; write only while idle.
// Pipeline: an input register, then the parse step (tag, LEB128 lengths,
//   name checks, 64-bit byte countdown) feeding a result register.
//   Each beat passes the input register and then the result register;
//   throughput is one byte per cycle while the output is not stalled.
// Stall: when out_stall holds a full result register, the input register
//   stops advancing and in_stall rises; nothing is dropped or repeated.
// Reset (rst, synchronous): both stages empty, parser back to expecting a
//   tag, no error, dest_length cleared. After a beat with last_byte the
//   parser rearms the same way but keeps dest_length.
// Errors are sticky: once status is nonzero every later byte up to the last
//   is reported as ignored.
module entry_stream_parser_validator #(
  parameter int NAME_LIMIT  = 2048,
  parameter int PATH_BUFFER = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  esp_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output esp_pkg::out_beat_t          out_data,
  input  logic                        cfg_we,
  input  logic [esp_pkg::DEST_W-1:0]  cfg_data
);

  // name lengths in the name phase stay below NAME_LIMIT
  localparam int LEN_W  = (NAME_LIMIT > 2) ? $clog2(NAME_LIMIT) : 1;
  localparam int PB_W   = $clog2(PATH_BUFFER + 1);
  localparam int MAX_W0 = (LEN_W > esp_pkg::DEST_W) ? LEN_W : esp_pkg::DEST_W;
  localparam int MAX_W1 = (MAX_W0 > PB_W) ? MAX_W0 : PB_W;
  localparam int SUM_W  = MAX_W1 + 1;

  // input register
  logic              s1_valid;
  esp_pkg::in_beat_t s1_beat;
  logic              s1_go;

  // configuration
  logic [esp_pkg::DEST_W-1:0] dest_length;

  // parser state
  esp_pkg::phase_t   phase, phase_next;
  logic [63:0]       varint_value, varint_value_next;
  logic [3:0]        varint_bytes, varint_bytes_next;
  logic              is_directory, is_directory_next;
  logic              tag_known, tag_known_next;
  logic [63:0]       bytes_left, bytes_left_next;
  esp_pkg::name_st_t name_st, name_st_next;
  esp_pkg::status_t  error_code, error_code_next;

  // step results
  esp_pkg::out_beat_t res;
  esp_pkg::status_t   err_step, err_out;

  logic [63:0]       vi_value;
  logic [3:0]        vi_count;
  logic              vi_complete, vi_too_long;
  logic [63:0]       bl_dec;
  logic              bl_zero;
  esp_pkg::name_st_t ns_out;
  logic [SUM_W-1:0]  path_sum;

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_length <= '0;
    end else if (cfg_we) begin
      dest_length <= cfg_data;
    end
  end

  esp_varint u_varint (
    .value      (varint_value),
    .count      (varint_bytes),
    .data_byte  (s1_beat.data_byte),
    .value_next (vi_value),
    .count_next (vi_count),
    .complete   (vi_complete),
    .too_long   (vi_too_long)
  );

  assign bl_dec  = bytes_left - 64'd1;
  assign bl_zero = (bl_dec == 64'd0);

  esp_name_step u_name (
    .cur        (name_st),
    .data_byte  (s1_beat.data_byte),
    .final_byte (bl_zero),
    .nxt        (ns_out)
  );

  assign path_sum = SUM_W'(dest_length) + SUM_W'(1) + SUM_W'(varint_value[LEN_W-1:0]);

  always_comb begin
    phase_next        = phase;
    varint_value_next = varint_value;
    varint_bytes_next = varint_bytes;
    is_directory_next = is_directory;
    tag_known_next    = tag_known;
    bytes_left_next   = bytes_left;
    name_st_next      = name_st;
    error_code_next   = error_code;

    res.byte_kind    = esp_pkg::KIND_IGNORED;
    res.entry_is_dir = 1'b0;
    res.entry_done   = 1'b0;
    res.stream_ok    = 1'b0;

    if (error_code == esp_pkg::ST_OK) begin
      case (phase)
        esp_pkg::PH_TAG: begin
          res.byte_kind     = esp_pkg::KIND_TAG;
          is_directory_next = (s1_beat.data_byte == 8'd1);
          tag_known_next    = (s1_beat.data_byte <= 8'd1);
          varint_value_next = 64'd0;
          varint_bytes_next = 4'd0;
          phase_next        = esp_pkg::PH_NLEN;
        end
        esp_pkg::PH_NLEN: begin
          res.byte_kind     = esp_pkg::KIND_NLEN;
          varint_value_next = vi_value;
          varint_bytes_next = vi_count;
          if (vi_too_long) begin
            error_code_next = esp_pkg::ST_VARINT;
          end else if (vi_complete) begin
            if (vi_value == 64'd0 || vi_value >= 64'(NAME_LIMIT)) begin
              error_code_next = esp_pkg::ST_NAME_LEN;
            end else begin
              bytes_left_next = vi_value;
              name_st_next    = esp_pkg::NAME_INIT;
              phase_next      = esp_pkg::PH_NAME;
            end
          end
        end
        esp_pkg::PH_NAME: begin
          res.byte_kind   = esp_pkg::KIND_NAME;
          name_st_next    = ns_out;
          bytes_left_next = bl_dec;
          if (bl_zero) begin
            // verdict order: name problems, path fit, then tag
            if (ns_out.pending != esp_pkg::ST_OK) begin
              error_code_next = ns_out.pending;
            end else if (path_sum >= SUM_W'(PATH_BUFFER)) begin
              error_code_next = esp_pkg::ST_NAME_LEN;
            end else if (!tag_known) begin
              error_code_next = esp_pkg::ST_BAD_TAG;
            end else if (is_directory) begin
              res.entry_done = 1'b1;
              phase_next     = esp_pkg::PH_TAG;
            end else begin
              varint_value_next = 64'd0;
              varint_bytes_next = 4'd0;
              phase_next        = esp_pkg::PH_CSIZE;
            end
          end
        end
        esp_pkg::PH_CSIZE: begin
          res.byte_kind     = esp_pkg::KIND_CSIZE;
          varint_value_next = vi_value;
          varint_bytes_next = vi_count;
          if (vi_too_long) begin
            error_code_next = esp_pkg::ST_VARINT;
          end else if (vi_complete) begin
            if (vi_value == 64'd0) begin
              res.entry_done = 1'b1;
              phase_next     = esp_pkg::PH_TAG;
            end else begin
              bytes_left_next = vi_value;
              phase_next      = esp_pkg::PH_CONTENT;
            end
          end
        end
        esp_pkg::PH_CONTENT: begin
          res.byte_kind   = esp_pkg::KIND_CONTENT;
          bytes_left_next = bl_dec;
          if (bl_zero) begin
            res.entry_done = 1'b1;
            phase_next     = esp_pkg::PH_TAG;
          end
        end
        default: begin
          phase_next = esp_pkg::PH_TAG;
        end
      endcase
      res.entry_is_dir = is_directory_next;
    end

    err_step = error_code_next;
    err_out  = err_step;
    if (s1_beat.last_byte) begin
      if (err_step == esp_pkg::ST_OK && phase_next != esp_pkg::PH_TAG) begin
        err_out = esp_pkg::ST_TRUNC;
      end
      res.stream_ok = (err_out == esp_pkg::ST_OK);
      // rearm for the next stream
      phase_next        = esp_pkg::PH_TAG;
      varint_value_next = 64'd0;
      varint_bytes_next = 4'd0;
      is_directory_next = 1'b0;
      tag_known_next    = 1'b0;
      bytes_left_next   = 64'd0;
      name_st_next      = esp_pkg::NAME_INIT;
      error_code_next   = esp_pkg::ST_OK;
    end
    res.status = err_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= esp_pkg::PH_TAG;
      varint_value <= 64'd0;
      varint_bytes <= 4'd0;
      is_directory <= 1'b0;
      tag_known    <= 1'b0;
      bytes_left   <= 64'd0;
      name_st      <= esp_pkg::NAME_INIT;
      error_code   <= esp_pkg::ST_OK;
    end else if (s1_go) begin
      phase        <= phase_next;
      varint_value <= varint_value_next;
      varint_bytes <= varint_bytes_next;
      is_directory <= is_directory_next;
      tag_known    <= tag_known_next;
      bytes_left   <= bytes_left_next;
      name_st      <= name_st_next;
      error_code   <= error_code_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data <= res;
    end
  end

  // a clean stream end never carries an error code
  a_ok_means_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stream_ok |-> out_data.status == esp_pkg::ST_OK)
    else $error("stream_ok with nonzero status");

  // a completed entry is never an ignored byte nor an errored one
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.entry_done |->
      out_data.status == esp_pkg::ST_OK && out_data.byte_kind != esp_pkg::KIND_IGNORED)
    else $error("entry_done on errored byte");

  // ignored bytes only occur under a sticky error
  a_ignored_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_kind == esp_pkg::KIND_IGNORED |->
      out_data.status != esp_pkg::ST_OK)
    else $error("ignored byte without error");

  // a processed byte always lands in the result register
  a_go_fills: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid)
    else $error("processed byte lost");

endmodule
